// File: design/iox_pkg.sv
package iox_pkg;

  localparam int unsigned DefTableDepth = 64;
  localparam int unsigned DefContigBits = 16;
  localparam int unsigned DefCoordBits  = 32;
  localparam int unsigned IdBits        = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BAD_IV = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_Q_REV  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_REB0,
    S_REB,
    S_QSCAN,
    S_RESP
  } bstate_e;

  // classification handed from front to back
  typedef struct packed {
    op_e  kind;
    logic bad_iv;   // start at or past end
    logic q_rev;    // start past end
    logic q_empty;  // start equal to end
  } cmd_flags_t;

  typedef struct packed {
    status_e           status;
    logic              hit;
    logic [IdBits-1:0] id;
    logic              last;
  } result_t;

endpackage

// File: design/iox_front.sv
module iox_front #(
  parameter int unsigned CONTIG_BITS = iox_pkg::DefContigBits,
  parameter int unsigned COORD_BITS  = iox_pkg::DefCoordBits
) (
  input  logic [1:0]                opcode_i,
  input  logic [15:0]               contig_i,
  input  logic [31:0]               range_start_i,
  input  logic [31:0]               range_end_i,
  output iox_pkg::cmd_flags_t       flags_o,
  output logic [CONTIG_BITS-1:0]    contig_o,
  output logic [COORD_BITS-1:0]     start_o,
  output logic [COORD_BITS-1:0]     end_o
);
  import iox_pkg::*;

  // mask or widen the fixed port fields to the stored widths
  if (CONTIG_BITS >= 16) begin : g_cw
    assign contig_o = CONTIG_BITS'(contig_i);
  end else begin : g_cn
    assign contig_o = contig_i[CONTIG_BITS-1:0];
  end

  if (COORD_BITS >= 32) begin : g_xw
    assign start_o = COORD_BITS'(range_start_i);
    assign end_o   = COORD_BITS'(range_end_i);
  end else begin : g_xn
    assign start_o = range_start_i[COORD_BITS-1:0];
    assign end_o   = range_end_i[COORD_BITS-1:0];
  end

  // classify the operation and its interval
  always_comb begin
    flags_o.kind    = op_e'(opcode_i);
    flags_o.bad_iv  = (start_o >= end_o);
    flags_o.q_rev   = (start_o > end_o);
    flags_o.q_empty = (start_o == end_o);
  end

endmodule

// File: design/iox_fifo.sv
module iox_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] rdata_o
);

  logic [W-1:0] slot_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count
  always_comb begin
    wp_d  = do_push ? !wp_q : wp_q;
    rp_d  = do_pop ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= wdata_i;
    end
  end

endmodule

// File: design/iox_back.sv
module iox_back #(
  parameter int unsigned TABLE_DEPTH = iox_pkg::DefTableDepth,
  parameter int unsigned CONTIG_BITS = iox_pkg::DefContigBits,
  parameter int unsigned COORD_BITS  = iox_pkg::DefCoordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  iox_pkg::cmd_flags_t          flags_i,
  input  logic [CONTIG_BITS-1:0]       contig_i,
  input  logic [COORD_BITS-1:0]        start_i,
  input  logic [COORD_BITS-1:0]        end_i,
  input  logic [iox_pkg::IdBits-1:0]   id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output iox_pkg::result_t             res_o
);
  import iox_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // table storage
  logic [CONTIG_BITS-1:0] mem_c [TABLE_DEPTH];
  logic [COORD_BITS-1:0]  mem_s [TABLE_DEPTH];
  logic [COORD_BITS-1:0]  mem_e [TABLE_DEPTH];
  logic [IdBits-1:0]      mem_o [TABLE_DEPTH];
  logic [COORD_BITS-1:0]  mem_m [TABLE_DEPTH];

  logic [AW-1:0]          rd_addr;
  logic [CONTIG_BITS-1:0] rc_q;
  logic [COORD_BITS-1:0]  rs_q, re_q, rm_q;
  logic [IdBits-1:0]      ro_q;

  logic                   ent_we, max_we;
  logic [AW-1:0]          ent_wa, max_wa;
  logic [CONTIG_BITS-1:0] w_c;
  logic [COORD_BITS-1:0]  w_s, w_e, w_m;
  logic [IdBits-1:0]      w_o;

  bstate_e                state_q, state_d;
  logic [CW-1:0]          idx_q, idx_d, pos_q, pos_d, cnt_q, cnt_d;
  logic [COORD_BITS-1:0]  m_q, m_d, m_new;
  logic [CONTIG_BITS-1:0] pc_q, pc_d;
  logic                   found_q, found_d, pend_q, pend_d;
  logic [IdBits-1:0]      pid_q, pid_d;
  result_t                resp_q, resp_d;

  logic [CONTIG_BITS-1:0] c_q;
  logic [COORD_BITS-1:0]  s_q, e_q;
  logic [IdBits-1:0]      o_q;
  logic                   latch;

  logic                   ov_q, slot_free, push;
  result_t                ores_q, push_res;
  logic                   key_lt, go;

  assign slot_free   = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign res_o       = ores_q;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign latch       = cmd_ready_o && cmd_valid_i;

  // new key sorts strictly before the entry on the read port
  always_comb begin
    if (c_q != rc_q)      key_lt = (c_q < rc_q);
    else if (s_q != rs_q) key_lt = (s_q < rs_q);
    else if (e_q != re_q) key_lt = (e_q < re_q);
    else                  key_lt = (o_q < ro_q);
  end

  // running maximum for the entry on the read port
  always_comb begin
    if (idx_q == '0 || rc_q != pc_q) m_new = re_q;
    else                             m_new = (re_q > m_q) ? re_q : m_q;
  end

  assign go = found_q || (rc_q == c_q && rm_q > s_q);

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    m_d      = m_q;
    pc_d     = pc_q;
    found_d  = found_q;
    pend_d   = pend_q;
    pid_d    = pid_q;
    resp_d   = resp_q;
    rd_addr  = idx_q[AW-1:0];
    ent_we   = 1'b0;
    ent_wa   = idx_q[AW-1:0];
    w_c      = rc_q;
    w_s      = rs_q;
    w_e      = re_q;
    w_o      = ro_q;
    max_we   = 1'b0;
    max_wa   = idx_q[AW-1:0];
    w_m      = m_new;
    push     = 1'b0;
    push_res = resp_q;
    case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        idx_d   = '0;
        resp_d  = '{status: STAT_OK, hit: 1'b0, id: '0, last: 1'b1};
        if (cmd_valid_i) begin
          case (flags_i.kind)
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_RESP;
            end
            OP_INSERT: begin
              if (flags_i.bad_iv) begin
                resp_d.status = STAT_BAD_IV;
                state_d       = S_RESP;
              end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
                resp_d.status = STAT_FULL;
                state_d       = S_RESP;
              end else begin
                state_d = S_FIND;
              end
            end
            OP_QUERY: begin
              if (flags_i.q_rev) begin
                resp_d.status = STAT_Q_REV;
                state_d       = S_RESP;
              end else if (flags_i.q_empty) begin
                state_d = S_RESP;
              end else begin
                found_d = 1'b0;
                pend_d  = 1'b0;
                state_d = S_QSCAN;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_FIND: begin
        if (idx_q == cnt_q || key_lt) begin
          pos_d   = idx_q;
          idx_d   = cnt_q;
          rd_addr = AW'(cnt_q - 1'b1);
          state_d = S_SHIFT;
        end else begin
          idx_d   = CW'(idx_q + 1'b1);
          rd_addr = AW'(idx_q + 1'b1);
        end
      end
      S_SHIFT: begin
        ent_we = 1'b1;
        if (idx_q == pos_q) begin
          w_c     = c_q;
          w_s     = s_q;
          w_e     = e_q;
          w_o     = o_q;
          cnt_d   = CW'(cnt_q + 1'b1);
          state_d = S_REB0;
        end else begin
          idx_d   = CW'(idx_q - 1'b1);
          rd_addr = AW'(idx_q - 2'd2);
        end
      end
      S_REB0: begin
        rd_addr = '0;
        idx_d   = '0;
        state_d = S_REB;
      end
      S_REB: begin
        if (idx_q == cnt_q) begin
          resp_d  = '{status: STAT_OK, hit: 1'b0, id: '0, last: 1'b1};
          state_d = S_RESP;
        end else begin
          max_we  = 1'b1;
          m_d     = m_new;
          pc_d    = rc_q;
          idx_d   = CW'(idx_q + 1'b1);
          rd_addr = AW'(idx_q + 1'b1);
        end
      end
      S_QSCAN: begin
        if (idx_q == cnt_q || (go && (rc_q != c_q || rs_q >= e_q))) begin
          // end of block: flush the held hit, if any, as the final result, else a miss
          resp_d  = pend_q ? '{status: STAT_OK, hit: 1'b1, id: pid_q, last: 1'b1}
                           : '{status: STAT_OK, hit: 1'b0, id: '0, last: 1'b1};
          state_d = S_RESP;
        end else if (go && re_q > s_q && pend_q) begin
          if (slot_free) begin
            push     = 1'b1;
            push_res = '{status: STAT_OK, hit: 1'b1, id: pid_q, last: 1'b0};
            pid_d    = ro_q;
            found_d  = 1'b1;
            idx_d    = CW'(idx_q + 1'b1);
            rd_addr  = AW'(idx_q + 1'b1);
          end
        end else begin
          if (go && re_q > s_q) begin
            pend_d = 1'b1;
            pid_d  = ro_q;
          end
          found_d = go;
          idx_d   = CW'(idx_q + 1'b1);
          rd_addr = AW'(idx_q + 1'b1);
        end
      end
      S_RESP: begin
        if (slot_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      if (push)             ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    m_q    <= m_d;
    pc_q   <= pc_d;
    pid_q  <= pid_d;
    resp_q <= resp_d;
    if (push) ores_q <= push_res;
    if (latch) begin
      c_q <= contig_i;
      s_q <= start_i;
      e_q <= end_i;
      o_q <= id_i;
    end
  end

  // memory ports: one write each, registered read
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      mem_c[ent_wa] <= w_c;
      mem_s[ent_wa] <= w_s;
      mem_e[ent_wa] <= w_e;
      mem_o[ent_wa] <= w_o;
    end
    if (max_we) begin
      mem_m[max_wa] <= w_m;
    end
    rc_q <= mem_c[rd_addr];
    rs_q <= mem_s[rd_addr];
    re_q <= mem_e[rd_addr];
    ro_q <= mem_o[rd_addr];
    rm_q <= mem_m[rd_addr];
  end

endmodule

// File: design/interval_overlap_index.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | opcode, contig, range_start/end, entry_id
// out     | output    | out_valid_o / out_ready_i | status, hit, match_id, last
//
// Clear, no-op and rejected inserts go from idle straight to the response state.
// A stored insert runs a search up to the insert point and a shift from the end
// back to it, then a running-maximum sweep, one table entry per cycle on the
// read port. A query scans the table in order from its first entry.
// Reset empties the table at once; two commands queue while the back end works,
// and a stalled output holds the scan in place.
module interval_overlap_index #(
  parameter int unsigned TABLE_DEPTH = iox_pkg::DefTableDepth,
  parameter int unsigned CONTIG_BITS = iox_pkg::DefContigBits,
  parameter int unsigned COORD_BITS  = iox_pkg::DefCoordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] contig_i,
  input  logic [31:0] range_start_i,
  input  logic [31:0] range_end_i,
  input  logic [31:0] entry_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        hit_o,
  output logic [31:0] match_id_o,
  output logic        last_o
);
  import iox_pkg::*;

  localparam int unsigned QW = $bits(cmd_flags_t) + CONTIG_BITS + 2 * COORD_BITS + IdBits;

  cmd_flags_t             f_flags, b_flags;
  logic [CONTIG_BITS-1:0] f_c, b_c;
  logic [COORD_BITS-1:0]  f_s, f_e, b_s, b_e;
  logic [IdBits-1:0]      b_o;
  logic                   q_full, q_empty, b_ready;
  logic [QW-1:0]          q_rdata;
  result_t                res;

  iox_front #(.CONTIG_BITS(CONTIG_BITS), .COORD_BITS(COORD_BITS)) u_front (
    .opcode_i     (opcode_i),
    .contig_i     (contig_i),
    .range_start_i(range_start_i),
    .range_end_i  (range_end_i),
    .flags_o      (f_flags),
    .contig_o     (f_c),
    .start_o      (f_s),
    .end_o        (f_e)
  );

  // command queue between classifier and sequencer
  iox_fifo #(.W(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .wdata_i({f_flags, f_c, f_s, f_e, entry_id_i}),
    .full_o (q_full),
    .pop_i  (b_ready),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  assign in_ready_o = !q_full;
  assign {b_flags, b_c, b_s, b_e, b_o} = q_rdata;

  iox_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CONTIG_BITS(CONTIG_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_ready_o(b_ready),
    .flags_i    (b_flags),
    .contig_i   (b_c),
    .start_i    (b_s),
    .end_i      (b_e),
    .id_i       (b_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign status_o   = res.status;
  assign hit_o      = res.hit;
  assign match_id_o = res.id;
  assign last_o     = res.last;

endmodule

// File: design/iox_checker.sv
module iox_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        hit_o,
  input logic [31:0] match_id_o,
  input logic        last_o
);
  import iox_pkg::*;

  // a stalled result transfer holds its id and last flag
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_id_o) && $stable(last_o))
    else $error("stalled result changed");

  // hits only come with an ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == STAT_OK)
    else $error("hit with error status");

  // a result without a hit closes its operation and carries no id
  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> last_o && match_id_o == '0)
    else $error("miss result not final or id set");

endmodule

bind interval_overlap_index iox_checker u_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import iox_pkg::*;

  localparam int unsigned Depth = DefTableDepth;

  // one outstanding result of the interval index
  typedef struct {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] match_id;
    logic        last;
  } iv_result_t;

  // interval table predictor and the queue of results it owes
  class overlap_scoreboard;
    logic [15:0] tab_contig[Depth];
    logic [31:0] tab_start[Depth];
    logic [31:0] tab_end[Depth];
    logic [31:0] tab_id[Depth];
    logic [31:0] tab_max[Depth];
    int unsigned n_entries;
    iv_result_t  owed[$];
    int unsigned n_errors;

    function new();
      n_entries = 0;
      n_errors  = 0;
    endfunction

    function void push(logic [1:0] st, logic h, logic [31:0] id, logic l);
      iv_result_t r;
      r.status = st; r.hit = h; r.match_id = id; r.last = l;
      owed = {owed, r};
    endfunction

    function bit sorts_first(logic [15:0] c, logic [31:0] s, logic [31:0] e,
                             logic [31:0] o, int unsigned i);
      if (c != tab_contig[i]) return c < tab_contig[i];
      if (s != tab_start[i]) return s < tab_start[i];
      if (e != tab_end[i]) return e < tab_end[i];
      return o < tab_id[i];
    endfunction

    function logic [1:0] place(logic [15:0] c, logic [31:0] s, logic [31:0] e,
                               logic [31:0] o);
      int unsigned pos;
      logic [31:0] m;
      if (s >= e) return STAT_BAD_IV;
      if (n_entries >= Depth) return STAT_FULL;
      pos = n_entries;
      for (int unsigned i = 0; i < n_entries; i++)
        if (sorts_first(c, s, e, o, i)) begin
          pos = i;
          break;
        end
      for (int unsigned i = n_entries; i > pos; i--) begin
        tab_contig[i] = tab_contig[i-1];
        tab_start[i]  = tab_start[i-1];
        tab_end[i]    = tab_end[i-1];
        tab_id[i]     = tab_id[i-1];
      end
      tab_contig[pos] = c; tab_start[pos] = s; tab_end[pos] = e; tab_id[pos] = o;
      n_entries++;
      m = 0;
      for (int unsigned i = 0; i < n_entries; i++) begin
        if (i == 0 || tab_contig[i] != tab_contig[i-1]) m = 0;
        if (tab_end[i] > m) m = tab_end[i];
        tab_max[i] = m;
      end
      return STAT_OK;
    endfunction

    // predict every result one accepted command causes
    function void note_command(logic [1:0] op, logic [15:0] c, logic [31:0] s,
                               logic [31:0] e, logic [31:0] o);
      int unsigned i;
      int unsigned hits;
      hits = 0;
      case (op)
        OP_CLEAR: begin
          n_entries = 0;
          push(STAT_OK, 0, 0, 1);
        end
        OP_INSERT: push(place(c, s, e, o), 0, 0, 1);
        OP_QUERY: begin
          if (s > e) push(STAT_Q_REV, 0, 0, 1);
          else begin
            if (s < e) begin
              for (i = 0; i < n_entries; i++)
                if (tab_contig[i] == c && tab_max[i] > s) break;
              for (; i < n_entries; i++) begin
                if (tab_contig[i] != c || tab_start[i] >= e) break;
                if (tab_end[i] > s) begin
                  push(STAT_OK, 1, tab_id[i], 0);
                  hits++;
                end
              end
            end
            if (hits == 0) push(STAT_OK, 0, 0, 1);
            else owed[$].last = 1;
          end
        end
        default: push(STAT_OK, 0, 0, 1);
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic h, logic [31:0] id, logic l);
      iv_result_t x;
      if (owed.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result st=%0d hit=%0b id=%h last=%0b",
                                     st, h, id, l);
        return;
      end
      x = owed.pop_front();
      if (x.status !== st || x.hit !== h || x.match_id !== id || x.last !== l) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch: exp st=%0d hit=%0b id=%h last=%0b, got st=%0d hit=%0b id=%h last=%0b",
                   x.status, x.hit, x.match_id, x.last, st, h, id, l);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  opcode = 0;
  logic [15:0] contig = 0;
  logic [31:0] range_start = 0, range_end = 0, entry_id = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic        hit;
  logic [31:0] match_id;
  logic        last;

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 87;

  overlap_scoreboard sb = new();

  always #6 clk = ~clk;

  interval_overlap_index u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .contig_i(contig), .range_start_i(range_start),
    .range_end_i(range_end), .entry_id_i(entry_id),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .hit_o(hit), .match_id_o(match_id), .last_o(last)
  );

  // result side: sample at the rising edge, stall at the falling edge
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(status, hit, match_id, last);

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // present one command and hold it until its transfer; valid drops only
  // in an idle cycle, so back to back commands keep it high
  task automatic send_cmd(logic [1:0] op, logic [15:0] c, logic [31:0] s,
                          logic [31:0] e, logic [31:0] o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; opcode <= op; contig <= c;
    range_start <= s; range_end <= e; entry_id <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(op, c, s, e, o);
    @(negedge clk);
  endtask

  // mostly a handful of contigs and a small coordinate window so queries hit
  task automatic send_random();
    logic [1:0]  op;
    logic [15:0] c;
    logic [31:0] s, e;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 3) op = OP_CLEAR;
    else if (k < 5) op = OP_NOP;
    else if (k < 50) op = OP_INSERT;
    else op = OP_QUERY;
    if ($urandom_range(9) == 0) begin
      c = 16'($urandom); s = $urandom; e = $urandom;
    end else begin
      c = 16'($urandom_range(3));
      s = $urandom_range(1000);
      e = s + $urandom_range(200);
      if ($urandom_range(15) == 0) e = s - $urandom_range(5);
      if ($urandom_range(9) == 0) begin
        s = s | 32'hFFFF_0000; e = e | 32'hFFFF_FF00;
      end
    end
    send_cmd(op, c, s, e, $urandom);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty table, extremes, duplicates, equal and reversed queries
    send_cmd(OP_QUERY, 0, 10, 20, 0);
    send_cmd(OP_INSERT, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_INSERT, 5, 100, 100, 1);
    send_cmd(OP_INSERT, 5, 200, 100, 2);
    send_cmd(OP_INSERT, 5, 100, 200, 3);
    send_cmd(OP_INSERT, 5, 100, 200, 3);
    send_cmd(OP_INSERT, 5, 50, 500, 0);
    send_cmd(OP_INSERT, 5, 300, 310, 7);
    send_cmd(OP_INSERT, 0, 0, 1, 32'h8000_0000);
    send_cmd(OP_QUERY, 5, 150, 320, 0);
    send_cmd(OP_QUERY, 5, 150, 150, 0);
    send_cmd(OP_QUERY, 5, 400, 399, 0);
    send_cmd(OP_QUERY, 5, 600, 700, 0);
    send_cmd(OP_QUERY, 16'hFFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
    send_cmd(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 0);
    send_cmd(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill to capacity, then overflow and an invalid insert on a full table
    for (int i = 0; i < Depth; i++) send_cmd(OP_INSERT, 1, 64 - i, 70 + i, i);
    send_cmd(OP_INSERT, 1, 1, 2, 99);
    send_cmd(OP_INSERT, 1, 2, 1, 99);
    send_cmd(OP_QUERY, 1, 0, 32'hFFFF_FFFF, 0);
    send_cmd(OP_CLEAR, 0, 0, 0, 0);
    send_cmd(OP_QUERY, 1, 0, 100, 0);

    // random traffic in three pressure phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 87; recv_idle_pct = 17;
      end else if (ph == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < 115; i++) send_random();
    end

    drain();
    if (sb.n_errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: interval_overlap_index.f
design/iox_pkg.sv
design/iox_front.sv
design/iox_fifo.sv
design/iox_back.sv
design/interval_overlap_index.sv
design/iox_checker.sv
sim/testbench.sv
